// ===== rtl/sfcp_pkg.sv =====
package sfcp_pkg;

   // Frame layout
   localparam logic [7:0] HDR_FIRST      = 8'h42;
   localparam logic [7:0] HDR_SECOND     = 8'h4D;
   localparam logic [4:0] FIRST_BODY_POS = 5'd2;
   localparam logic [4:0] DATA_FIRST_POS = 5'd4;
   localparam logic [4:0] DATA_LAST_POS  = 5'd27;
   localparam logic [4:0] LAST_SUM_POS   = 5'd29;
   localparam logic [4:0] CHECK_HIGH_POS = 5'd30;
   localparam logic [4:0] FRAME_LAST_POS = 5'd31;

   // Sum value right after both header bytes
   localparam logic [15:0] HDR_SUM = 16'(HDR_FIRST) + 16'(HDR_SECOND);

   localparam int unsigned NUM_WORDS = 12;
   localparam logic [3:0]  WORD_IDX_FIRST = 4'd0;
   localparam logic [3:0]  WORD_IDX_LAST  = 4'(NUM_WORDS - 1);

   // Result status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER2,
      PH_COLLECT
   } phase_type;

   typedef logic [NUM_WORDS-1:0][15:0] word_array_type;

   // Frame completion event from the framer to the emitter
   typedef struct packed {
      logic valid;
      logic ok;
   } frame_done_type;

endpackage

// ===== rtl/sfcp_if.sv =====
interface sfcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfcp_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [3:0]  word_index;
   logic [15:0] word_value;
   logic        last;

   modport source (output valid, output status, output word_index, output word_value,
                   output last, input ready);
   modport sink   (input valid, input status, input word_index, input word_value,
                   input last, output ready);
endinterface

// ===== rtl/sfcp_framer.sv =====
module sfcp_framer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  logic [7:0]              rx_byte,
   input  logic                    emit_busy,
   output logic                    ready,
   output sfcp_pkg::frame_done_type done,
   output sfcp_pkg::word_array_type words
);
   import sfcp_pkg::*;

   phase_type      phase_ff, phase_in;
   logic [4:0]     pos_ff, pos_in;
   logic [15:0]    sum_ff, sum_in;
   logic [7:0]     chk_hi_ff, chk_hi_in;
   word_array_type store_ff;

   logic           store_we;
   logic           store_hi;
   logic [4:0]     pos_rel;
   logic [3:0]     store_idx;

   // Data word slot for the current frame position
   assign pos_rel   = pos_ff - DATA_FIRST_POS;
   assign store_idx = pos_rel[4:1];

   // Hold off the closing word while the previous frame is still draining
   assign ready = !(phase_ff == PH_COLLECT && pos_ff == FRAME_LAST_POS && emit_busy);

   assign words = store_ff;

   // Advance the frame state for each accepted word
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      chk_hi_in  = chk_hi_ff;
      store_we   = 1'b0;
      store_hi   = !pos_ff[0];
      done.valid = 1'b0;
      done.ok    = ({chk_hi_ff, rx_byte} == sum_ff);
      if (take) begin
         unique case (phase_ff)
            PH_HEADER2: begin
               if (rx_byte == HDR_SECOND) begin
                  phase_in = PH_COLLECT;
                  pos_in   = FIRST_BODY_POS;
                  sum_in   = HDR_SUM;
               end else begin
                  phase_in = PH_HUNT;
                  pos_in   = '0;
                  sum_in   = '0;
               end
            end
            PH_COLLECT: begin
               priority if (pos_ff <= LAST_SUM_POS) begin
                  sum_in   = sum_ff + 16'(rx_byte);
                  store_we = (pos_ff >= DATA_FIRST_POS) && (pos_ff <= DATA_LAST_POS);
                  pos_in   = pos_ff + 5'd1;
               end else if (pos_ff == CHECK_HIGH_POS) begin
                  chk_hi_in = rx_byte;
                  pos_in    = FRAME_LAST_POS;
               end else begin
                  // closing checksum byte: report and return to hunting
                  done.valid = 1'b1;
                  phase_in   = PH_HUNT;
                  pos_in     = '0;
                  sum_in     = '0;
               end
            end
            default: begin
               phase_in = (rx_byte == HDR_FIRST) ? PH_HEADER2 : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         pos_ff    <= '0;
         sum_ff    <= '0;
         chk_hi_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         sum_ff    <= sum_in;
         chk_hi_ff <= chk_hi_in;
      end
   end

   // Fill the data words: high byte first, then low byte
   always_ff @(posedge clock) begin
      if (store_we) begin
         if (store_hi) begin
            store_ff[store_idx] <= {rx_byte, 8'h00};
         end else begin
            store_ff[store_idx][7:0] <= rx_byte;
         end
      end
   end

endmodule

// ===== rtl/sfcp_emitter.sv =====
module sfcp_emitter (
   input  logic                     clock,
   input  logic                     reset,
   input  sfcp_pkg::frame_done_type done,
   input  sfcp_pkg::word_array_type words,
   input  logic                     out_ready,
   output logic                     busy,
   output logic                     status,
   output logic [3:0]               word_index,
   output logic [15:0]              word_value,
   output logic                     last
);
   import sfcp_pkg::*;

   logic           busy_ff, busy_in;
   logic           status_ff, status_in;
   logic [3:0]     index_ff, index_in;
   word_array_type shift_ff, shift_in;
   logic           send;

   assign busy       = busy_ff;
   assign status     = status_ff;
   assign word_index = index_ff;
   assign word_value = shift_ff[0];
   assign last       = (status_ff == STATUS_BAD) || (index_ff == WORD_IDX_LAST);
   assign send       = busy_ff && out_ready;

   // Load a finished frame, then shift one word out per handshake
   always_comb begin
      busy_in   = busy_ff;
      status_in = status_ff;
      index_in  = index_ff;
      shift_in  = shift_ff;
      if (done.valid) begin
         busy_in   = 1'b1;
         status_in = done.ok ? STATUS_OK : STATUS_BAD;
         index_in  = WORD_IDX_FIRST;
         shift_in  = done.ok ? words : '0;
      end else if (send) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            index_in = index_ff + 4'd1;
            for (int i = 0; i < NUM_WORDS - 1; i++) begin
               shift_in[i] = shift_ff[i+1];
            end
            shift_in[NUM_WORDS-1] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      index_ff  <= index_in;
      shift_ff  <= shift_in;
   end

endmodule

// ===== rtl/sensor_frame_checksum_parser.sv =====
// Serial frame parser for a particulate sensor.
// req_chan carries one received byte per word (valid/ready). The block hunts
// for the header 0x42 0x4D, collects the rest of the 32-byte frame and checks
// the 16-bit sum of bytes 0 to 29 against the big-endian checksum in bytes 30-31.
// rsp_chan returns, starting the cycle after the closing byte is taken, either
// twelve data words (word_index 0 to 11, last on the twelfth) or a single
// error word (status 1, value 0, last 1).
// Throughput: one byte per cycle while req_chan.ready is high; each byte is handled
// in the cycle it is accepted by the framer registers. Results leave one per cycle
// while rsp_chan.ready is high, from a 12-entry output shift register.
// When rsp_chan stalls, bytes keep flowing into the next frame; only the
// closing byte of that frame is held off (req_chan.ready low) until every
// result of the previous frame has been taken.
// Reset (synchronous, active high) returns to hunting, clears the sum and
// drops any results not yet delivered.
module sensor_frame_checksum_parser (
   input logic        clock,
   input logic        reset,
   sfcp_req_if.sink   req_chan,
   sfcp_rsp_if.source rsp_chan
);
   import sfcp_pkg::*;

   frame_done_type done;
   word_array_type words;
   logic           emit_busy;
   logic           take;

   assign take = req_chan.valid && req_chan.ready;

   sfcp_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_chan.rx_byte),
      .emit_busy (emit_busy),
      .ready     (req_chan.ready),
      .done      (done),
      .words     (words)
   );

   sfcp_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .done       (done),
      .words      (words),
      .out_ready  (rsp_chan.ready),
      .busy       (emit_busy),
      .status     (rsp_chan.status),
      .word_index (rsp_chan.word_index),
      .word_value (rsp_chan.word_value),
      .last       (rsp_chan.last)
   );

   assign rsp_chan.valid = emit_busy;

endmodule

// ===== test/tb_sensor_frame_checksum_parser.sv =====
`timescale 1ns / 100ps

module tb_sensor_frame_checksum_parser;
   import sfcp_pkg::*;

   localparam int unsigned FRAME_BYTES      = 32;
   localparam int unsigned RANDOM_BYTES     = 150;
   localparam int unsigned LONG_HOLD_AFTER  = 14;
   localparam int unsigned LONG_HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES     = 40;
   localparam int unsigned TIMEOUT_NS       = 2_000_000;

   typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_kind_type;

   typedef struct packed {
      logic        status;
      logic [3:0]  word_index;
      logic [15:0] word_value;
      logic        last;
   } frame_word_type;

   // Tracks the frame parser state and holds the data words still owed
   class frame_scoreboard;
      phase_type      state;
      logic [4:0]     pos;
      logic [15:0]    sum;
      logic [7:0]     check_high;
      logic [15:0]    words [NUM_WORDS];
      frame_word_type due [$];
      int unsigned    errors;
      int unsigned    words_taken;

      function new();
         rewind();
         check_high  = '0;
         errors      = 0;
         words_taken = 0;
         foreach (words[i]) words[i] = '0;
      endfunction

      function void rewind();
         state = PH_HUNT;
         pos   = '0;
         sum   = '0;
      endfunction

      // Advance the parser by one accepted byte; queue the words of a closed frame
      function void note_byte(logic [7:0] b);
         frame_word_type w;
         int unsigned k;
         case (state)
            PH_HEADER2: begin
               if (b == HDR_SECOND) begin
                  state = PH_COLLECT;
                  pos   = FIRST_BODY_POS;
                  sum   = HDR_SUM;
               end else begin
                  rewind();
               end
            end
            PH_COLLECT: begin
               if (pos <= LAST_SUM_POS) begin
                  sum = sum + 16'(b);
                  if (pos >= DATA_FIRST_POS && pos <= DATA_LAST_POS) begin
                     k = 32'((pos - DATA_FIRST_POS) >> 1);
                     if (!pos[0]) words[k] = {b, 8'h00};
                     else words[k][7:0] = b;
                  end
                  pos = pos + 5'd1;
               end else if (pos == CHECK_HIGH_POS) begin
                  check_high = b;
                  pos        = FRAME_LAST_POS;
               end else begin
                  if ({check_high, b} != sum) begin
                     w.status     = STATUS_BAD;
                     w.word_index = WORD_IDX_FIRST;
                     w.word_value = 16'h0000;
                     w.last       = 1'b1;
                     due.push_back(w);
                  end else begin
                     for (k = 0; k < NUM_WORDS; k++) begin
                        w.status     = STATUS_OK;
                        w.word_index = 4'(k);
                        w.word_value = words[k];
                        w.last       = (4'(k) == WORD_IDX_LAST);
                        due.push_back(w);
                     end
                  end
                  rewind();
               end
            end
            default: begin
               if (b == HDR_FIRST) state = PH_HEADER2;
               else state = PH_HUNT;
            end
         endcase
      endfunction

      // Compare one delivered word against the oldest owed one
      function void check_word(frame_word_type got);
         frame_word_type want;
         words_taken++;
         if (due.size() == 0) begin
            $display("%0t: unexpected word: status %0d index %0d value %h last %0d",
                     $time, got.status, got.word_index, got.word_value, got.last);
            errors++;
            return;
         end
         want = due.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.word_index !== want.word_index) begin
            $display("%0t: word_index expected %0d actual %0d",
                     $time, want.word_index, got.word_index);
            errors++;
         end
         if (got.word_value !== want.word_value) begin
            $display("%0t: word_value expected %h actual %h",
                     $time, want.word_value, got.word_value);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;
   int unsigned sent;
   frame_scoreboard board;

   sfcp_req_if req_chan ();
   sfcp_rsp_if rsp_chan ();

   sensor_frame_checksum_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Random byte with extra weight on the extremes
   function automatic logic [7:0] data_byte();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   task automatic put_byte(input logic [7:0] b);
      int unsigned n;
      n = steady ? 0 : idle_cycles();
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent++;
   endtask

   // Build a frame with a correct or spoiled checksum; send its first len bytes
   task automatic send_frame(input fill_kind_type fill, input bit bad_sum,
                             input int unsigned len);
      logic [7:0]  frame [FRAME_BYTES];
      logic [15:0] total;
      int unsigned i;
      frame[0] = HDR_FIRST;
      frame[1] = HDR_SECOND;
      total    = HDR_SUM;
      for (i = 2; i < 30; i++) begin
         case (fill)
            FILL_ONES:  frame[i] = 8'hFF;
            FILL_ZEROS: frame[i] = 8'h00;
            default:    frame[i] = data_byte();
         endcase
         total = total + 16'(frame[i]);
      end
      if (bad_sum) total = total ^ 16'($urandom_range(1, 16'hFFFF));
      frame[30] = total[15:8];
      frame[31] = total[7:0];
      for (i = 0; i < len; i++) put_byte(frame[i]);
   endtask

   // Watch both channels
   always @(posedge clock) begin
      frame_word_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) board.note_byte(req_chan.rx_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.status     = rsp_chan.status;
            got.word_index = rsp_chan.word_index;
            got.word_value = rsp_chan.word_value;
            got.last       = rsp_chan.last;
            board.check_word(got);
         end
      end
   end

   // Result side: random stalls, ready bursts, one long hold-off to back up the input
   initial begin
      bit held_once;
      int unsigned n;
      held_once = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!held_once && board.words_taken >= LONG_HOLD_AFTER) begin
            held_once = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         n = idle_cycles();
         if (n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) repeat (16) @(posedge clock);
         else @(posedge clock);
      end
   end

   // Stimulus
   initial begin
      int unsigned start;
      int unsigned r;
      int unsigned n;
      logic [7:0]  b;
      board = new();
      sent  = 0;
      steady = 1'b0;
      reset <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Drop bytes while hunting; a repeated first header byte must not restart
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(HDR_SECOND);
      put_byte(HDR_FIRST);
      put_byte(HDR_FIRST);
      put_byte(HDR_SECOND);
      put_byte(HDR_FIRST);
      put_byte(8'h00);

      // Extreme frames: all-ones data with good sum, all-zeros with bad sum
      send_frame(FILL_ONES, 1'b0, FRAME_BYTES);
      send_frame(FILL_ZEROS, 1'b1, FRAME_BYTES);

      // Mostly whole frames, plus bad sums, broken headers, cut frames and noise
      start = sent;
      while (sent - start < RANDOM_BYTES) begin
         steady = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 55) begin
            send_frame(FILL_RANDOM, 1'b0, FRAME_BYTES);
         end else if (r < 70) begin
            send_frame(FILL_RANDOM, 1'b1, FRAME_BYTES);
         end else if (r < 80) begin
            b = 8'($urandom);
            if (b == HDR_SECOND) b = b ^ 8'h80;
            put_byte(HDR_FIRST);
            put_byte($urandom_range(0, 1) ? HDR_FIRST : b);
         end else if (r < 86) begin
            send_frame(FILL_RANDOM, 1'b0, $urandom_range(3, FRAME_BYTES - 1));
         end else begin
            n = $urandom_range(1, 5);
            repeat (n) put_byte(data_byte());
         end
      end
      steady = 1'b0;
      req_chan.valid <= 1'b0;

      // Drain owed words, then leave time for strays
      while (board.due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sfcp_pkg.sv
rtl/sfcp_if.sv
rtl/sfcp_framer.sv
rtl/sfcp_emitter.sv
rtl/sensor_frame_checksum_parser.sv
test/tb_sensor_frame_checksum_parser.sv
